>>> sv/rcp_pkg.sv
// Shared types and constants for the rectangle cut pieces block.
package rcp_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int MAX_PIECES = 4;
	localparam int CNT_BITS   = $clog2(MAX_PIECES + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [SIZE_BITS-1:0]         size_t;
	typedef logic signed [COORD_BITS:0]   ext_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;

	typedef enum logic [2:0] {
		KIND_LEFT   = 3'd0,
		KIND_RIGHT  = 3'd1,
		KIND_TOP    = 3'd2,
		KIND_BOTTOM = 3'd3,
		KIND_WHOLE  = 3'd4,
		KIND_EMPTY  = 3'd5
	} kind_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		size_t  w;
		size_t  h;
	} rect_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		size_t  w;
		size_t  h;
		kind_t  kind;
	} piece_t;

endpackage

>>> sv/rcp_calc.sv
// Combinational piece generation: edge compares, piece geometry and slot packing.
module rcp_calc import rcp_pkg::*; (
	input  rect_t  subj,
	input  rect_t  cut,
	output piece_t pieces [MAX_PIECES],
	output cnt_t   count
);

	ext_t sx, sy, sw, sh, sr, sb;
	ext_t cx, cy, cw, ch, cr, cb;
	ext_t lo, hi;
	ext_t d_left, d_right, d_span, d_top, d_bottom;
	logic [MAX_PIECES-1:0] hit;
	logic covered;
	piece_t cand [MAX_PIECES];

	always_comb begin
		sx = {subj.x[COORD_BITS-1], subj.x};
		sy = {subj.y[COORD_BITS-1], subj.y};
		sw = {2'b00, subj.w};
		sh = {2'b00, subj.h};
		cx = {cut.x[COORD_BITS-1], cut.x};
		cy = {cut.y[COORD_BITS-1], cut.y};
		cw = {2'b00, cut.w};
		ch = {2'b00, cut.h};
		sr = sx + sw;
		sb = sy + sh;
		cr = cx + cw;
		cb = cy + ch;

		// cut's horizontal extent clamped to the subject span
		lo = (cx > sx) ? cx : sx;
		if (lo > sr)
			lo = sr;
		hi = (cr < sr) ? cr : sr;
		if (hi < sx)
			hi = sx;

		d_left   = cx - sx;
		d_right  = sr - cr;
		d_span   = hi - lo;
		d_top    = cy - sy;
		d_bottom = sb - cb;

		hit[0] = (cx > sx) && (cx < sr);
		hit[1] = (cr > sx) && (cr < sr);
		hit[2] = (lo != hi) && (cy > sy) && (cy < sb);
		hit[3] = (lo != hi) && (cb > sy) && (cb < sb);
		covered = (cx <= sx) && (cr >= sr) && (cy <= sy) && (cb >= sb);

		cand[0] = '{x: subj.x, y: subj.y, w: d_left[SIZE_BITS-1:0], h: subj.h,
			kind: KIND_LEFT};
		cand[1] = '{x: cr[COORD_BITS-1:0], y: subj.y, w: d_right[SIZE_BITS-1:0],
			h: subj.h, kind: KIND_RIGHT};
		cand[2] = '{x: lo[COORD_BITS-1:0], y: subj.y, w: d_span[SIZE_BITS-1:0],
			h: d_top[SIZE_BITS-1:0], kind: KIND_TOP};
		cand[3] = '{x: lo[COORD_BITS-1:0], y: cb[COORD_BITS-1:0],
			w: d_span[SIZE_BITS-1:0], h: d_bottom[SIZE_BITS-1:0], kind: KIND_BOTTOM};
	end

	// pack the pieces that arise into consecutive slots, in order; if none, slot 0 holds a whole or empty piece
	always_comb begin
		for (int j = 0; j < MAX_PIECES; j++)
			pieces[j] = cand[j];
		count = '0;
		for (int i = 0; i < MAX_PIECES; i++) begin
			if (hit[i]) begin
				pieces[count[CNT_BITS-2:0]] = cand[i];
				count = count + cnt_t'(1);
			end
		end
		if (count == '0) begin
			if (covered)
				pieces[0] = '{x: '0, y: '0, w: '0, h: '0, kind: KIND_EMPTY};
			else
				pieces[0] = '{x: subj.x, y: subj.y, w: subj.w, h: subj.h,
					kind: KIND_WHOLE};
			count = cnt_t'(1);
		end
	end

endmodule

>>> sv/rcp_queue.sv
// Piece register: holds one item's pieces and shifts them out, one per cycle.
module rcp_queue import rcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  piece_t pieces [MAX_PIECES],
	input  cnt_t   count,
	output logic   can_load,
	output logic   strobe,
	output logic   last,
	output piece_t head
);

	piece_t slot_q [MAX_PIECES];
	cnt_t   cnt_q;

	// free now, or emptying in this cycle
	assign can_load = (cnt_q <= cnt_t'(1));
	assign strobe   = (cnt_q != '0);
	assign last     = (cnt_q == cnt_t'(1));
	assign head     = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= count;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= pieces;
		end else if (cnt_q != '0) begin
			for (int i = 0; i < MAX_PIECES - 1; i++)
				slot_q[i] <= slot_q[i+1];
		end
	end

endmodule

>>> sv/rectangle_cut_pieces_unit.sv
// Top level of the rectangle cut pieces block.
//
// Each item (subject and cut rectangle) yields one to four pieces, given one
// per cycle on strobe, with last_piece high on the final one; the receiver
// cannot stall. An item taken is registered in the input register, its pieces
// are computed from it and loaded into the piece register once that register
// can take them, and the first piece shows straight from the piece register.
// An item that gives n pieces occupies the piece register until its last
// piece is out, so the sustained rate is one item per n pieces (one to four),
// set by the single-piece-per-cycle result port. busy is high while the input
// register holds an item the piece register cannot yet take.
module rectangle_cut_pieces_unit import rcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t subj_x,
	input  coord_t subj_y,
	input  size_t  subj_width,
	input  size_t  subj_height,
	input  coord_t cut_x,
	input  coord_t cut_y,
	input  size_t  cut_width,
	input  size_t  cut_height,
	output logic   strobe,
	output coord_t piece_x,
	output coord_t piece_y,
	output size_t  piece_width,
	output size_t  piece_height,
	output logic [2:0] piece_kind,
	output logic   last_piece
);

	logic   v_s1;
	rect_t  subj_s1;
	rect_t  cut_s1;
	piece_t pieces [MAX_PIECES];
	cnt_t   count;
	logic   can_load;
	logic   load;
	logic   accept;
	piece_t head;

	assign load   = v_s1 && can_load;
	assign busy   = v_s1 && !can_load;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			subj_s1 <= '{x: subj_x, y: subj_y, w: subj_width, h: subj_height};
			cut_s1  <= '{x: cut_x, y: cut_y, w: cut_width, h: cut_height};
		end
	end

	rcp_calc u_calc (
		.subj   (subj_s1),
		.cut    (cut_s1),
		.pieces (pieces),
		.count  (count)
	);

	rcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.pieces   (pieces),
		.count    (count),
		.can_load (can_load),
		.strobe   (strobe),
		.last     (last_piece),
		.head     (head)
	);

	assign piece_x      = head.x;
	assign piece_y      = head.y;
	assign piece_width  = head.w;
	assign piece_height = head.h;
	assign piece_kind   = head.kind;

endmodule
